[rtl/core/dtht_pkg.sv]
// ----------------------------------------------------------------------------
// dtht_pkg
// Shared types, codes and defaults of the dependency time horizon table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dtht_pkg;

  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_TIME_WIDTH  = 32;

  typedef enum logic [1:0] {
    CMD_REGISTER = 2'd0,
    CMD_NOTIFY   = 2'd1,
    CMD_REQUEST  = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_UNKNOWN = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_RSVD    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_START = 2'd0,
    CFG_STOP  = 2'd1,
    CFG_EPS   = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_ADD1,
    ST_ADD2,
    ST_FIN
  } state_t;

  localparam logic [31:0] RST_START = 32'h0000_0000;
  localparam logic [31:0] RST_STOP  = 32'hFFFF_FFFF;
  localparam logic [15:0] RST_EPS   = 16'h0001;

endpackage : dtht_pkg

`default_nettype wire

[rtl/core/dtht_ram.sv]
// ----------------------------------------------------------------------------
// dtht_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dtht_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : dtht_ram

`default_nettype wire

[rtl/core/dtht_sat_add.sv]
// ----------------------------------------------------------------------------
// dtht_sat_add
// Shared saturating time adder; clamps to all ones on carry out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dtht_sat_add #(
  parameter int TIME_WIDTH = 32
) (
  input  wire logic [TIME_WIDTH-1:0] a,
  input  wire logic [TIME_WIDTH-1:0] b,
  output logic      [TIME_WIDTH-1:0] y
);

  logic [TIME_WIDTH:0] sum;

  always_comb begin
    sum = {1'b0, a} + {1'b0, b};
    y   = sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : sum[TIME_WIDTH-1:0];
  end

endmodule : dtht_sat_add

`default_nettype wire

[rtl/core/dependency_time_horizon_table_unit.sv]
// ----------------------------------------------------------------------------
// dependency_time_horizon_table_unit
// Conservative look-ahead time synchronizer over a table of upstream sources.
// ----------------------------------------------------------------------------
// Usage: one input beat (cmd, source_id, time_value, step_len) gives exactly
// one output beat (horizon, proceed, wake, status). Both channels are
// valid/ready. Commands: register a source, notify a source time, or request
// a step; see status for unknown source or full table.
// Timing: the table lives in a RAM with registered read, scanned one entry
// per cycle to find the source and the minimum horizon. The scan is
// followed by ST_LAST, ST_ADD1, ST_ADD2 and ST_FIN; on an empty table the
// command goes straight to ST_ADD1. A new beat is taken only once the
// sequencer is back in ST_IDLE. One shared saturating adder handles the
// two sums after the scan.
// The output is registered: the next beat is taken while a result still
// waits, but the final step of that next beat stalls until the output
// register is free, so a stalled receiver holds the whole block.
// Config writes (cfg_we, cfg_index, cfg_data) are taken at any edge and are
// expected only while no command is in flight.
// Reset: clears fill count and waiting flag, sets config defaults; the table
// RAM needs no clearing pass since only slots below the fill count are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dependency_time_horizon_table_unit #(
  parameter int TABLE_DEPTH = dtht_pkg::DEF_TABLE_DEPTH,
  parameter int TIME_WIDTH  = dtht_pkg::DEF_TIME_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] source_id,
  input  wire logic [31:0] time_value,
  input  wire logic [31:0] step_len,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      horizon,
  output logic             proceed,
  output logic             wake,
  output logic [1:0]       status
);

  localparam int TW  = TIME_WIDTH;
  localparam int TW1 = TIME_WIDTH + 1;
  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int RW  = 32 + 2 * TIME_WIDTH;

  // config
  logic [TW-1:0] start_time, stop_time, eps;

  // sequencer
  dtht_pkg::state_t state, state_next;
  logic             fin_go, out_free;

  // latched command
  dtht_pkg::cmd_t cmd_q;
  logic [31:0]    src_q;
  logic [TW-1:0]  tv_q, dt_q;

  // table state
  logic [CW-1:0] cnt;
  logic          waiting;
  logic [TW-1:0] wait_target;

  // scan
  logic [AW-1:0] scan_idx, pend_idx;
  logic          rd_pending;
  logic          any_other, match;
  logic [TW-1:0] min_other, hk, dk;
  logic [AW-1:0] match_idx;

  // RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata, ram_rdata;
  logic [31:0]   rd_src;
  logic [TW-1:0] rd_hor;

  // shared adder
  logic [TW-1:0] add_a, add_b, add_y, s1, s2;

  // final step
  logic          any_all, full, finished, grant, do_wake;
  logic [TW-1:0] min_all, base_min, kh, kd, new_min, res_horizon;
  dtht_pkg::status_t res_status;

  dtht_ram #(.WIDTH(RW), .DEPTH(TABLE_DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  dtht_sat_add #(.TIME_WIDTH(TW)) u_add (
    .a (add_a),
    .b (add_b),
    .y (add_y)
  );

  assign rd_src = ram_rdata[2*TW +: 32];
  assign rd_hor = ram_rdata[0 +: TW];

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      start_time <= TW'(dtht_pkg::RST_START);
      stop_time  <= TW'(dtht_pkg::RST_STOP);
      eps        <= TW'(dtht_pkg::RST_EPS);
    end else if (cfg_we) begin
      unique case (dtht_pkg::cfg_idx_t'(cfg_index))
        dtht_pkg::CFG_START: start_time <= TW'(cfg_data);
        dtht_pkg::CFG_STOP:  stop_time  <= TW'(cfg_data);
        dtht_pkg::CFG_EPS:   eps        <= TW'(cfg_data[15:0]);
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dtht_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (cnt == '0) ? dtht_pkg::ST_ADD1 : dtht_pkg::ST_SCAN;
        end
      end
      dtht_pkg::ST_SCAN: begin
        if (CW'(scan_idx) == cnt - CW'(1)) begin
          state_next = dtht_pkg::ST_LAST;
        end
      end
      dtht_pkg::ST_LAST: state_next = dtht_pkg::ST_ADD1;
      dtht_pkg::ST_ADD1: state_next = dtht_pkg::ST_ADD2;
      dtht_pkg::ST_ADD2: state_next = dtht_pkg::ST_FIN;
      dtht_pkg::ST_FIN: begin
        if (out_free) begin
          state_next = dtht_pkg::ST_IDLE;
        end
      end
      default: state_next = dtht_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = (state == dtht_pkg::ST_IDLE) && !rst;
    out_free = !out_valid || out_ready;
    fin_go   = (state == dtht_pkg::ST_FIN) && out_free;
    add_a    = tv_q;
    add_b    = eps;
    unique case (state)
      dtht_pkg::ST_ADD1: begin
        unique case (cmd_q)
          dtht_pkg::CMD_REGISTER: begin add_a = start_time; add_b = tv_q; end
          dtht_pkg::CMD_NOTIFY:   begin add_a = tv_q;       add_b = dk;   end
          default:                begin add_a = tv_q;       add_b = dt_q; end
        endcase
      end
      dtht_pkg::ST_ADD2: begin
        add_a = (cmd_q == dtht_pkg::CMD_REQUEST) ? min_all : s1;
        add_b = eps;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtht_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // command latch, scan pipeline and adder results
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
      any_other  <= 1'b0;
      match      <= 1'b0;
      scan_idx   <= '0;
    end else begin
      rd_pending <= (state == dtht_pkg::ST_SCAN);
      pend_idx   <= scan_idx;
      if (in_valid && in_ready) begin
        cmd_q     <= dtht_pkg::cmd_t'(cmd);
        src_q     <= source_id;
        tv_q      <= TW'(time_value);
        dt_q      <= TW'(step_len);
        scan_idx  <= '0;
        any_other <= 1'b0;
        match     <= 1'b0;
      end else if (state == dtht_pkg::ST_SCAN) begin
        scan_idx <= scan_idx + AW'(1);
      end
      // entry read last cycle is checked here
      if (rd_pending) begin
        if (rd_src == src_q) begin
          match     <= 1'b1;
          match_idx <= pend_idx;
          hk        <= rd_hor;
          dk        <= ram_rdata[TW +: TW];
        end else if (!any_other || rd_hor < min_other) begin
          min_other <= rd_hor;
          any_other <= 1'b1;
        end
      end
      if (state == dtht_pkg::ST_ADD1) s1 <= add_y;
      if (state == dtht_pkg::ST_ADD2) s2 <= add_y;
    end
  end

  // final decision; s1 and s2 are the two adder results
  always_comb begin
    any_all  = any_other || match;
    min_all  = !any_other ? hk : ((match && hk < min_other) ? hk : min_other);
    base_min = any_all ? min_all : stop_time;
    full     = (cnt == CW'(TABLE_DEPTH));
    finished = (TW1'(tv_q) + TW1'(eps)) > TW1'(stop_time);
    grant    = (cnt == '0) || finished || !(s2 < s1);

    if (cmd_q == dtht_pkg::CMD_REGISTER) begin
      kh = match ? ((s2 < hk) ? s2 : hk) : s2;
      kd = match ? ((tv_q < dk) ? tv_q : dk) : tv_q;
    end else begin
      kh = (s2 > hk) ? s2 : hk;
      kd = dk;
    end
    new_min = (any_other && min_other < kh) ? min_other : kh;

    ram_we      = 1'b0;
    do_wake     = 1'b0;
    res_horizon = base_min;
    res_status  = dtht_pkg::STAT_OK;
    unique case (cmd_q)
      dtht_pkg::CMD_REGISTER: begin
        if (match || !full) begin
          ram_we      = fin_go;
          res_horizon = new_min;
        end else begin
          res_status = dtht_pkg::STAT_FULL;
        end
      end
      dtht_pkg::CMD_NOTIFY: begin
        if (match) begin
          ram_we      = fin_go;
          res_horizon = new_min;
          do_wake     = waiting && !(new_min < wait_target);
        end else begin
          res_status = dtht_pkg::STAT_UNKNOWN;
        end
      end
      default: ;
    endcase
    ram_waddr = match ? match_idx : cnt[AW-1:0];
    ram_wdata = {src_q, kd, kh};
  end

  // table bookkeeping and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      waiting     <= 1'b0;
      wait_target <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (fin_go) begin
        out_valid <= 1'b1;
        horizon   <= 32'(res_horizon);
        status    <= res_status;
        proceed   <= 1'b0;
        wake      <= do_wake;
        if (cmd_q == dtht_pkg::CMD_REGISTER && !match && !full) begin
          cnt <= cnt + CW'(1);
        end
        if (do_wake) begin
          waiting     <= 1'b0;
          wait_target <= '0;
        end
        if (cmd_q == dtht_pkg::CMD_REQUEST) begin
          proceed <= grant;
          if (grant) begin
            waiting     <= 1'b0;
            wait_target <= '0;
          end else begin
            waiting     <= 1'b1;
            wait_target <= s1;
          end
        end
      end
    end
  end

  // assertions
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_cnt_only_at_fin: assert property (@(posedge clk) disable iff (rst)
    !fin_go |=> cnt == $past(cnt))
    else $error("fill count moved outside final step");

  a_flags_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (proceed || wake) |-> status == dtht_pkg::STAT_OK)
    else $error("grant or wake reported with error status");

  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_pending |-> (state == dtht_pkg::ST_SCAN || state == dtht_pkg::ST_LAST))
    else $error("read data pending outside scan");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != dtht_pkg::ST_IDLE)
    else $error("accepted beat did not start the sequencer");

endmodule : dependency_time_horizon_table_unit

`default_nettype wire
